@@ rtl/core/assert_macros.svh @@
// assertion macros for the recogniser rtl
// expects a clock named clk and a synchronous reset named rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pda_pkg.sv @@
// types and codes of the pushdown recogniser
// no dependencies; used by pushdown_automaton_step
package pda_pkg;

  localparam logic [2:0] OP_FEED    = 3'd0;
  localparam logic [2:0] OP_PLAIN   = 3'd1;
  localparam logic [2:0] OP_KEYED   = 3'd2;
  localparam logic [2:0] OP_FINAL   = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_EDGE   = 3'd1;
  localparam logic [2:0] ERR_INVALID   = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd4;

  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  localparam int APB_AW = 3;
  localparam logic [APB_AW-1:0] REG_START_ADDR = 3'd0;

  typedef struct packed {
    logic [5:0] target;
    logic [2:0] push;
    logic [1:0] action;
    logic       present;
  } edge_entry_t;

  typedef struct packed {
    logic [2:0] push_symbol;
    logic [1:0] stack_action;
    logic [5:0] target_state;
    logic       entry_present;
    logic [2:0] top_symbol;
    logic [5:0] from_state;
    logic [5:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic       in_final;
    logic [6:0] stack_depth;
    logic [5:0] state_now;
    logic [2:0] error_code;
    logic       accepted;
  } out_word_t;

endpackage

@@ rtl/core/pushdown_automaton_step.sv @@
// Table-driven deterministic pushdown recogniser. Each word on the input stream is handled
// in order: first the edge table and stack reads keyed by the current state and the cached
// stack top, then a step that resolves the edge, writes the tables or stack and launches
// the final flag read of the new state. No new word is taken while one is in that step or
// while the two-word output buffer, where results wait, has no room for its result. After
// reset a clearing pass empties both edge tables and the final flags, walking every address
// of the keyed table; no input word is taken during it, while register writes are.
// Uses pda_pkg, pda_ram and assert_macros.svh.
`include "assert_macros.svh"

module pushdown_automaton_step
  import pda_pkg::*;
#(
  parameter int NUM_STATES        = 64,
  parameter int NUM_SYMBOLS       = 64,
  parameter int NUM_STACK_SYMBOLS = 8,
  parameter int STACK_DEPTH       = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // symbol, from_state, top_symbol, entry_present, target_state, stack_action, push_symbol
  input  logic [31:0]       s_tdata,
  // opcode
  input  logic [2:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // accepted, error_code, state_now, stack_depth, in_final
  output logic [23:0]       m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SW  = $clog2(NUM_STATES);
  localparam int YW  = $clog2(NUM_SYMBOLS);
  localparam int TW  = $clog2(NUM_STACK_SYMBOLS);
  localparam int PW  = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int PAW = SW + YW;
  localparam int KAW = PAW + TW;
  localparam int EW  = $bits(edge_entry_t);

  // architectural state
  logic [5:0]    start_reg;
  logic [5:0]    node;
  logic          run_valid;
  logic [DW-1:0] sp;
  logic [2:0]    top;

  // clearing pass
  logic           clr_busy;
  logic [KAW-1:0] clr_addr;

  // engine stages
  logic        s1_v;
  logic [2:0]  s1_op;
  in_word_t    s1_w;
  logic        s2_v;
  logic        s2_acc;
  logic [2:0]  s2_err;
  logic        s2_byp;
  logic        s2_byp_val;
  logic        s2_fail;

  // output buffer
  out_word_t   o0;
  out_word_t   o1;
  logic [1:0]  out_cnt;
  out_word_t   res;
  logic        push_out;
  logic        pop_out;

  // memory ports
  in_word_t       in_w;
  edge_entry_t    plain_rd;
  edge_entry_t    keyed_rd;
  edge_entry_t    edge_wr;
  edge_entry_t    sel;
  logic [2:0]     stk_rd;
  logic           final_rd;
  logic           plain_en;
  logic [PAW-1:0] plain_waddr;
  logic           keyed_en;
  logic [KAW-1:0] keyed_waddr;
  logic           final_en;
  logic [SW-1:0]  final_waddr;
  logic           final_wdata;

  // stage one decisions
  logic          run_valid_next;
  logic [5:0]    node_next;
  logic [DW-1:0] sp_next;
  logic [2:0]    top_next;
  logic          acc;
  logic [2:0]    err;
  logic          plain_we;
  logic          keyed_we;
  logic          final_we;
  logic          stk_we;
  logic          byp;
  logic          feed_ok;
  logic          wr_ok;

  assign in_w = in_word_t'(s_tdata[$bits(in_word_t)-1:0]);

  assign pready = 1'b1;
  assign prdata = (paddr == REG_START_ADDR) ? 32'(start_reg) : 32'd0;

  assign s_tready = !clr_busy && !s1_v && ((2'(s2_v) + out_cnt) < 2'd2);

  // edge resolution and all table, stack and state updates
  always_comb begin
    sel = (keyed_rd.present && sp != '0) ? keyed_rd : plain_rd;
    feed_ok = (int'(node) < NUM_STATES) && (int'(s1_w.symbol) < NUM_SYMBOLS) && sel.present;
    wr_ok = (int'(s1_w.from_state) < NUM_STATES) && (int'(s1_w.symbol) < NUM_SYMBOLS)
         && (int'(s1_w.target_state) < NUM_STATES)
         && (int'(s1_w.push_symbol) < NUM_STACK_SYMBOLS);
    edge_wr = '0;
    if (s1_w.entry_present) begin
      edge_wr.present = 1'b1;
      edge_wr.action  = s1_w.stack_action;
      edge_wr.push    = s1_w.push_symbol;
      edge_wr.target  = s1_w.target_state;
    end
    run_valid_next = run_valid;
    node_next      = node;
    sp_next        = sp;
    top_next       = top;
    acc            = 1'b0;
    err            = ERR_NONE;
    plain_we       = 1'b0;
    keyed_we       = 1'b0;
    final_we       = 1'b0;
    stk_we         = 1'b0;
    byp            = 1'b0;
    unique case (s1_op)
      OP_FEED: begin
        if (!run_valid) begin
          err = ERR_INVALID;
        end else if (!feed_ok) begin
          run_valid_next = 1'b0;
          err            = ERR_NO_EDGE;
        end else if (sel.action == ACT_PUSH && int'(sp) >= STACK_DEPTH) begin
          run_valid_next = 1'b0;
          err            = ERR_OVERFLOW;
        end else if (sel.action == ACT_POP && sp == '0) begin
          run_valid_next = 1'b0;
          err            = ERR_UNDERFLOW;
        end else begin
          acc       = 1'b1;
          node_next = sel.target;
          if (sel.action == ACT_PUSH) begin
            stk_we   = 1'b1;
            sp_next  = sp + DW'(1);
            top_next = sel.push;
          end else if (sel.action == ACT_POP) begin
            sp_next  = sp - DW'(1);
            top_next = stk_rd;
          end
        end
      end
      OP_PLAIN: begin
        if (wr_ok) begin
          plain_we = 1'b1;
          acc      = 1'b1;
        end
      end
      OP_KEYED: begin
        if (wr_ok && int'(s1_w.top_symbol) < NUM_STACK_SYMBOLS) begin
          keyed_we = 1'b1;
          acc      = 1'b1;
        end
      end
      OP_FINAL: begin
        if (int'(s1_w.from_state) < NUM_STATES) begin
          final_we = 1'b1;
          acc      = 1'b1;
          byp      = (s1_w.from_state == node);
        end
      end
      OP_RESTART: begin
        run_valid_next = 1'b1;
        node_next      = start_reg;
        sp_next        = '0;
        acc            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // write ports shared between the clearing pass and the engine
  always_comb begin
    plain_en    = clr_busy || (s1_v && plain_we);
    plain_waddr = clr_busy ? clr_addr[PAW-1:0] : {SW'(s1_w.from_state), YW'(s1_w.symbol)};
    keyed_en    = clr_busy || (s1_v && keyed_we);
    keyed_waddr = clr_busy ? clr_addr
                : {SW'(s1_w.from_state), YW'(s1_w.symbol), TW'(s1_w.top_symbol)};
    final_en    = clr_busy || (s1_v && final_we);
    final_waddr = clr_busy ? clr_addr[SW-1:0] : SW'(s1_w.from_state);
    final_wdata = !clr_busy && s1_w.entry_present;
  end

  pda_ram #(.WIDTH(EW), .DEPTH(2 ** PAW)) u_plain (
    .clk     (clk),
    .wr_en   (plain_en),
    .wr_addr (plain_waddr),
    .wr_data (clr_busy ? EW'(0) : EW'(edge_wr)),
    .rd_addr ({SW'(node), YW'(in_w.symbol)}),
    .rd_data (plain_rd)
  );

  pda_ram #(.WIDTH(EW), .DEPTH(2 ** KAW)) u_keyed (
    .clk     (clk),
    .wr_en   (keyed_en),
    .wr_addr (keyed_waddr),
    .wr_data (clr_busy ? EW'(0) : EW'(edge_wr)),
    .rd_addr ({SW'(node), YW'(in_w.symbol), TW'(top)}),
    .rd_data (keyed_rd)
  );

  // the symbol below the top is read ahead so a pop can refill the cached top
  pda_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (s1_v && stk_we),
    .wr_addr (PW'(sp)),
    .wr_data (sel.push),
    .rd_addr (PW'(sp - DW'(2))),
    .rd_data (stk_rd)
  );

  pda_ram #(.WIDTH(1), .DEPTH(2 ** SW)) u_final (
    .clk     (clk),
    .wr_en   (final_en),
    .wr_addr (final_waddr),
    .wr_data (final_wdata),
    .rd_addr (SW'(node_next)),
    .rd_data (final_rd)
  );

  always_comb begin
    res.accepted    = s2_acc;
    res.error_code  = s2_err;
    res.state_now   = node;
    res.stack_depth = 7'(sp);
    res.in_final    = run_valid && (int'(node) < NUM_STATES)
                    && (s2_byp ? s2_byp_val : final_rd);
  end

  assign push_out = s2_v;
  assign pop_out  = m_tvalid && m_tready;
  assign m_tvalid = (out_cnt != 2'd0);
  assign m_tdata  = 24'(o0);

  assign s2_fail = s2_v && (s2_err == ERR_NO_EDGE || s2_err == ERR_OVERFLOW
                         || s2_err == ERR_UNDERFLOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg <= '0;
      node      <= '0;
      run_valid <= 1'b1;
      sp        <= '0;
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_cnt   <= 2'd0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_START_ADDR) begin
        start_reg <= pwdata[5:0];
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + KAW'(1);
        if (clr_addr == '1) begin
          clr_busy <= 1'b0;
        end
      end
      s1_v <= s_tvalid && s_tready;
      s2_v <= s1_v;
      if (s1_v) begin
        node      <= node_next;
        run_valid <= run_valid_next;
        sp        <= sp_next;
      end
      unique case ({push_out, pop_out})
        2'b10:   out_cnt <= out_cnt + 2'd1;
        2'b01:   out_cnt <= out_cnt - 2'd1;
        default: out_cnt <= out_cnt;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op <= s_tuser;
      s1_w  <= in_w;
    end
    if (s1_v) begin
      top        <= top_next;
      s2_acc     <= acc;
      s2_err     <= err;
      s2_byp     <= byp;
      s2_byp_val <= s1_w.entry_present;
    end
    unique case ({push_out, pop_out})
      2'b11: begin
        if (out_cnt == 2'd1) begin
          o0 <= res;
        end else begin
          o0 <= o1;
          o1 <= res;
        end
      end
      2'b10: begin
        if (out_cnt == 2'd0) begin
          o0 <= res;
        end else begin
          o1 <= res;
        end
      end
      2'b01:   o0 <= o1;
      default: o0 <= o0;
    endcase
  end

  `ASSERT_ALWAYS(a_out_bound, out_cnt <= 2'd2, "output buffer overrun")
  `ASSERT_ALWAYS(a_sp_bound, int'(sp) <= STACK_DEPTH, "stack pointer beyond depth")
  `ASSERT_SAME(a_clr_quiet, clr_busy, !s1_v && !s2_v, "word in flight during clearing")
  `ASSERT_NEXT(a_s1_to_s2, s1_v, s2_v && !s1_v, "engine stage sequence broken")
  `ASSERT_SAME(a_err_sticky, s2_fail, !run_valid, "failed word left run valid")

endmodule

@@ rtl/core/pda_ram.sv @@
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module pda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
